[sv/bcmp_pkg.sv]
// Shared types and constants for the binomial coefficient mod prime block.
// Used by bcmp_modmul, bcmp_datapath, bcmp_ctrl and the top level; no dependencies.
package bcmp_pkg;

    localparam int N_W = 30;
    localparam int K_W = 16;
    localparam int IDX_W = K_W + 1;
    localparam int EXP_BITS = 30;
    localparam int PW_W = 5;

    localparam int MAX_CHOOSE = 65535;

    localparam logic [N_W-1:0] PRIME = 30'd1000000007;
    localparam logic [31:0] PRIME_X2 = 32'd2000000014;
    localparam logic [EXP_BITS-1:0] EXPONENT = PRIME - 30'd2;

    // Barrett reciprocal floor(2^60 / p)
    localparam logic [63:0] BARRETT_WIDE = (64'd1 << 60) / 64'd1000000007;
    localparam logic [30:0] BARRETT_M = BARRETT_WIDE[30:0];

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOP,
        ST_COMBINE,
        ST_CWAIT,
        ST_POWER,
        ST_FINAL,
        ST_FWAIT,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        B_ACC,
        B_TERM,
        B_TERM1,
        B_IDX,
        B_IDX1
    } bsel_t;

    typedef struct packed {
        logic        issue;
        logic [1:0]  a_sel;
        bsel_t       b_sel;
        logic [1:0]  b_acc;
        logic [1:0]  dst;
        logic        load;
        logic        step;
        logic        init_res;
        logic        out_load;
    } cmd_t;

    typedef struct packed {
        logic in_bad;
        logic in_kzero;
        logic second_ok;
        logic loop_last;
    } status_t;

endpackage

[sv/bcmp_modmul.sv]
// Pipelined modular multiplier, a*b mod p, Barrett reduction over three register stages.
// Depends on bcmp_pkg for the modulus and reciprocal constants.
module bcmp_modmul
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [bcmp_pkg::N_W-1:0]   in_a,
    input  logic [bcmp_pkg::N_W-1:0]   in_b,
    input  logic [1:0]                 in_dst,
    output logic                       out_valid,
    output logic [1:0]                 out_dst,
    output logic [bcmp_pkg::N_W-1:0]   out_res
);

    logic [2:0]  valid_reg;
    logic [2:0]  valid_next;
    logic [1:0]  dst1_reg, dst2_reg, dst3_reg;
    logic [59:0] p1_reg, p2_reg, p3_reg;
    logic [59:0] p1_next;
    logic [61:0] t2_reg, t2_next;
    logic [59:0] q3_reg, q3_next;
    logic [29:0] q_est;
    logic [31:0] r_raw;
    logic [31:0] r_fix;

    assign valid_next = {valid_reg[1:0], in_valid};
    assign p1_next = 60'(in_a) * 60'(in_b);
    assign t2_next = 62'(p1_reg[59:29]) * 62'(bcmp_pkg::BARRETT_M);
    assign q_est = t2_reg[60:31];
    assign q3_next = 60'(q_est) * 60'(bcmp_pkg::PRIME);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_reg   <= p1_next;
        dst1_reg <= in_dst;
        t2_reg   <= t2_next;
        p2_reg   <= p1_reg;
        dst2_reg <= dst1_reg;
        q3_reg   <= q3_next;
        p3_reg   <= p2_reg;
        dst3_reg <= dst2_reg;
    end

    // estimate is low by at most two multiples of p
    always_comb
    begin
        r_raw = p3_reg[31:0] - q3_reg[31:0];
        if (r_raw >= bcmp_pkg::PRIME_X2)
        begin
            r_fix = r_raw - bcmp_pkg::PRIME_X2;
        end
        else if (r_raw >= 32'(bcmp_pkg::PRIME))
        begin
            r_fix = r_raw - 32'(bcmp_pkg::PRIME);
        end
        else
        begin
            r_fix = r_raw;
        end
    end

    assign out_valid = valid_reg[2];
    assign out_dst   = dst3_reg;
    assign out_res   = r_fix[29:0];

    a_res_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_res < bcmp_pkg::PRIME))
        else $error("modmul result not reduced");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid |-> ##3 out_valid)
        else $error("modmul result missing after issue");

endmodule

[sv/bcmp_datapath.sv]
// Datapath: operand registers, four product accumulators, operand select and result register.
// Depends on bcmp_pkg and instantiates bcmp_modmul.
module bcmp_datapath
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [bcmp_pkg::N_W-1:0]   set_size,
    input  logic [bcmp_pkg::K_W-1:0]   choose_count,
    input  bcmp_pkg::cmd_t             cmd,
    output bcmp_pkg::status_t          status,
    output logic [bcmp_pkg::N_W-1:0]   binomial
);

    localparam int N_W = bcmp_pkg::N_W;
    localparam int K_W = bcmp_pkg::K_W;
    localparam int IDX_W = bcmp_pkg::IDX_W;

    logic [N_W-1:0]   acc0_reg, acc1_reg, acc2_reg, acc3_reg;
    logic [N_W-1:0]   acc0_next, acc1_next, acc2_next, acc3_next;
    logic [N_W-1:0]   term_reg, term_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [K_W-1:0]   k_reg, k_next;
    logic [N_W-1:0]   binomial_reg, binomial_next;

    logic [N_W-1:0]   term_red;
    logic [N_W:0]     term1;
    logic [N_W-1:0]   term1_red;
    logic [IDX_W-1:0] idx1;
    logic [N_W-1:0]   a_val;
    logic [N_W-1:0]   b_acc_val;
    logic [N_W-1:0]   b_val;

    logic             mm_valid;
    logic [1:0]       mm_dst;
    logic [N_W-1:0]   mm_res;

    assign term_red = (term_reg >= bcmp_pkg::PRIME) ? (term_reg - bcmp_pkg::PRIME) : term_reg;
    assign term1 = {1'b0, term_reg} + 31'd1;
    assign term1_red = (term1 >= {1'b0, bcmp_pkg::PRIME}) ?
                       N_W'(term1 - {1'b0, bcmp_pkg::PRIME}) : term1[N_W-1:0];
    assign idx1 = idx_reg + IDX_W'(1);

    assign status.in_bad = ({14'd0, choose_count} > set_size) ||
                           ({1'b0, choose_count} > IDX_W'(bcmp_pkg::MAX_CHOOSE));
    assign status.in_kzero = (choose_count == '0);
    assign status.second_ok = (idx1 <= {1'b0, k_reg});
    assign status.loop_last = (idx1 >= {1'b0, k_reg});

    always_comb
    begin
        case (cmd.a_sel)
            2'd0:    a_val = acc0_reg;
            2'd1:    a_val = acc1_reg;
            2'd2:    a_val = acc2_reg;
            2'd3:    a_val = acc3_reg;
            default: a_val = acc0_reg;
        endcase
    end

    always_comb
    begin
        case (cmd.b_acc)
            2'd0:    b_acc_val = acc0_reg;
            2'd1:    b_acc_val = acc1_reg;
            2'd2:    b_acc_val = acc2_reg;
            2'd3:    b_acc_val = acc3_reg;
            default: b_acc_val = acc0_reg;
        endcase
    end

    always_comb
    begin
        case (cmd.b_sel)
            bcmp_pkg::B_ACC:   b_val = b_acc_val;
            bcmp_pkg::B_TERM:  b_val = term_red;
            bcmp_pkg::B_TERM1: b_val = term1_red;
            bcmp_pkg::B_IDX:   b_val = {13'd0, idx_reg};
            bcmp_pkg::B_IDX1:  b_val = {13'd0, idx1};
            default:           b_val = b_acc_val;
        endcase
    end

    bcmp_modmul u_modmul
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.issue),
        .in_a      (a_val),
        .in_b      (b_val),
        .in_dst    (cmd.dst),
        .out_valid (mm_valid),
        .out_dst   (mm_dst),
        .out_res   (mm_res)
    );

    always_comb
    begin
        acc0_next = acc0_reg;
        acc1_next = acc1_reg;
        acc2_next = acc2_reg;
        acc3_next = acc3_reg;
        term_next = term_reg;
        idx_next  = idx_reg;
        k_next    = k_reg;
        binomial_next = binomial_reg;
        if (cmd.load)
        begin
            acc0_next = status.in_bad ? N_W'(0) : N_W'(1);
            acc1_next = N_W'(1);
            acc2_next = N_W'(1);
            acc3_next = N_W'(1);
            term_next = N_W'(set_size - N_W'(choose_count) + N_W'(1));
            idx_next  = IDX_W'(1);
            k_next    = choose_count;
        end
        else
        begin
            if (mm_valid)
            begin
                case (mm_dst)
                    2'd0:    acc0_next = mm_res;
                    2'd1:    acc1_next = mm_res;
                    2'd2:    acc2_next = mm_res;
                    2'd3:    acc3_next = mm_res;
                    default: acc0_next = mm_res;
                endcase
            end
            if (cmd.init_res)
            begin
                acc2_next = N_W'(1);
            end
            if (cmd.step)
            begin
                term_next = term_reg + N_W'(2);
                idx_next  = idx_reg + IDX_W'(2);
            end
        end
        if (cmd.out_load)
        begin
            binomial_next = acc0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        acc0_reg <= acc0_next;
        acc1_reg <= acc1_next;
        acc2_reg <= acc2_next;
        acc3_reg <= acc3_next;
        term_reg <= term_next;
        idx_reg  <= idx_next;
        k_reg    <= k_next;
        binomial_reg <= binomial_next;
    end

    assign binomial = binomial_reg;

endmodule

[sv/bcmp_ctrl.sv]
// Controller: sequences the product loop, combine, Fermat exponentiation and output transfer.
// Depends on bcmp_pkg for the state type and the command and status structs.
module bcmp_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  bcmp_pkg::status_t   status,
    output bcmp_pkg::cmd_t      cmd
);

    localparam int PW_W = bcmp_pkg::PW_W;

    bcmp_pkg::state_t state_reg, state_next;
    logic [1:0]       slot_reg, slot_next;
    logic [PW_W-1:0]  pw_reg, pw_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bcmp_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (status.in_bad)
                        state_next = bcmp_pkg::ST_DONE;
                    else if (status.in_kzero)
                        state_next = bcmp_pkg::ST_COMBINE;
                    else
                        state_next = bcmp_pkg::ST_LOOP;
                end
            end
            bcmp_pkg::ST_LOOP:
            begin
                if (slot_reg == 2'd3 && status.loop_last)
                    state_next = bcmp_pkg::ST_COMBINE;
            end
            bcmp_pkg::ST_COMBINE:
            begin
                if (slot_reg == 2'd3)
                    state_next = bcmp_pkg::ST_CWAIT;
            end
            bcmp_pkg::ST_CWAIT:
            begin
                if (slot_reg == 2'd3)
                    state_next = bcmp_pkg::ST_POWER;
            end
            bcmp_pkg::ST_POWER:
            begin
                if (slot_reg == 2'd3 && pw_reg == PW_W'(bcmp_pkg::EXP_BITS - 1))
                    state_next = bcmp_pkg::ST_FINAL;
            end
            bcmp_pkg::ST_FINAL:
            begin
                if (slot_reg == 2'd3)
                    state_next = bcmp_pkg::ST_FWAIT;
            end
            bcmp_pkg::ST_FWAIT:
            begin
                if (slot_reg == 2'd3)
                    state_next = bcmp_pkg::ST_DONE;
            end
            bcmp_pkg::ST_DONE:
            begin
                if (out_free)
                    state_next = bcmp_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = bcmp_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        slot_next = slot_reg;
        pw_next = pw_reg;
        if (state_reg == bcmp_pkg::ST_IDLE || state_reg == bcmp_pkg::ST_DONE)
        begin
            slot_next = 2'd0;
            pw_next = '0;
        end
        else
        begin
            slot_next = slot_reg + 2'd1;
            if (state_reg == bcmp_pkg::ST_POWER && slot_reg == 2'd3)
                pw_next = pw_reg + PW_W'(1);
        end
    end

    always_comb
    begin
        if (state_reg == bcmp_pkg::ST_DONE && out_free)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // slot schedule reads each accumulator only after its pending multiplier result is written back
    always_comb
    begin
        cmd = '0;
        cmd.b_sel = bcmp_pkg::B_ACC;
        in_ready = 1'b0;
        case (state_reg)
            bcmp_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            bcmp_pkg::ST_LOOP:
            begin
                case (slot_reg)
                    2'd0:
                    begin
                        cmd.issue = 1'b1;
                        cmd.a_sel = 2'd0;
                        cmd.b_sel = bcmp_pkg::B_TERM;
                        cmd.dst = 2'd0;
                    end
                    2'd1:
                    begin
                        cmd.issue = 1'b1;
                        cmd.a_sel = 2'd1;
                        cmd.b_sel = bcmp_pkg::B_IDX;
                        cmd.dst = 2'd1;
                    end
                    2'd2:
                    begin
                        cmd.issue = status.second_ok;
                        cmd.a_sel = 2'd2;
                        cmd.b_sel = bcmp_pkg::B_TERM1;
                        cmd.dst = 2'd2;
                    end
                    default:
                    begin
                        cmd.issue = status.second_ok;
                        cmd.a_sel = 2'd3;
                        cmd.b_sel = bcmp_pkg::B_IDX1;
                        cmd.dst = 2'd3;
                        cmd.step = 1'b1;
                    end
                endcase
            end
            bcmp_pkg::ST_COMBINE:
            begin
                if (slot_reg == 2'd2)
                begin
                    cmd.issue = 1'b1;
                    cmd.a_sel = 2'd2;
                    cmd.b_acc = 2'd0;
                    cmd.dst = 2'd0;
                end
                else if (slot_reg == 2'd3)
                begin
                    cmd.issue = 1'b1;
                    cmd.a_sel = 2'd3;
                    cmd.b_acc = 2'd1;
                    cmd.dst = 2'd1;
                    cmd.init_res = 1'b1;
                end
            end
            bcmp_pkg::ST_POWER:
            begin
                if (slot_reg == 2'd0)
                begin
                    cmd.issue = 1'b1;
                    cmd.a_sel = 2'd1;
                    cmd.b_acc = 2'd1;
                    cmd.dst = 2'd1;
                end
                else if (slot_reg == 2'd1)
                begin
                    cmd.issue = bcmp_pkg::EXPONENT[pw_reg];
                    cmd.a_sel = 2'd2;
                    cmd.b_acc = 2'd1;
                    cmd.dst = 2'd2;
                end
            end
            bcmp_pkg::ST_FINAL:
            begin
                if (slot_reg == 2'd1)
                begin
                    cmd.issue = 1'b1;
                    cmd.a_sel = 2'd0;
                    cmd.b_acc = 2'd2;
                    cmd.dst = 2'd0;
                end
            end
            bcmp_pkg::ST_DONE:
            begin
                cmd.out_load = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bcmp_pkg::ST_IDLE;
            slot_reg <= '0;
            pw_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            slot_reg <= slot_next;
            pw_reg <= pw_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_done_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bcmp_pkg::ST_DONE && out_free) |=> out_valid_reg)
        else $error("result not presented after done");

    a_no_issue_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bcmp_pkg::ST_IDLE || state_reg == bcmp_pkg::ST_DONE) |-> !cmd.issue)
        else $error("multiplier issued outside busy states");

endmodule

[sv/binomial_coefficient_mod_prime.sv]
// Binomial coefficient C(n,k) mod 1000000007, one item at a time.
// Work runs through the modular multiplier pipeline: two loop steps per round, 30 rounds
// of square-and-multiply, plus combine and final multiply rounds; k > n goes straight to done.
// The next input is taken once the result is presented.
// Reset: asynchronous active low; controller returns to idle, no result pending, no clearing pass.
module binomial_coefficient_mod_prime
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [bcmp_pkg::N_W-1:0]   set_size,
    input  logic [bcmp_pkg::K_W-1:0]   choose_count,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [bcmp_pkg::N_W-1:0]   binomial
);

    bcmp_pkg::cmd_t    cmd;
    bcmp_pkg::status_t status;

    bcmp_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    bcmp_datapath u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .set_size     (set_size),
        .choose_count (choose_count),
        .cmd          (cmd),
        .status       (status),
        .binomial     (binomial)
    );

endmodule

[dv/tb_binomial_coefficient_mod_prime.sv]
// Testbench for binomial_coefficient_mod_prime: a directed table, then random n/k transfers,
// each result checked against a local C(n,k) mod p predictor. Depends on bcmp_pkg and the DUT.
// Random idling on both channels, one long output hold-off and one input drain pause.
module tb_binomial_coefficient_mod_prime;

    localparam int N_W = bcmp_pkg::N_W;
    localparam int K_W = bcmp_pkg::K_W;
    localparam int MAX_CHOOSE = bcmp_pkg::MAX_CHOOSE;
    localparam logic [N_W-1:0] PRIME = bcmp_pkg::PRIME;
    localparam logic [63:0] PRIME_WIDE = 64'(PRIME);
    localparam logic [N_W-1:0] N_ALL_ONES = '1;
    localparam int NUM_DIRECTED = 24;
    localparam int NUM_RANDOM = 76;
    localparam int HOLD_CYCLES = 600;
    localparam int HOLD_AFTER = 20;
    localparam int WATCHDOG_LIMIT = 1000000;

    typedef struct {
        logic [N_W-1:0] n;
        logic [K_W-1:0] k;
        bit             known;
        logic [N_W-1:0] val;
    } row_t;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           in_valid = 1'b0;
    logic           in_ready;
    logic [N_W-1:0] set_size = '0;
    logic [K_W-1:0] choose_count = '0;
    logic           out_valid;
    logic           out_ready = 1'b0;
    logic [N_W-1:0] binomial;

    logic [N_W-1:0] binom_due [$];
    logic [N_W-1:0] binom_want;
    row_t           directed_rows [NUM_DIRECTED];
    int             fail_count = 0;
    int             results_seen = 0;
    int             quiet_cycles = 0;
    bit             steady = 1'b0;

    binomial_coefficient_mod_prime dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .set_size     (set_size),
        .choose_count (choose_count),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .binomial     (binomial)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [63:0] mul_mod_p(logic [63:0] a, logic [63:0] b);
        return ((a % PRIME_WIDE) * (b % PRIME_WIDE)) % PRIME_WIDE;
    endfunction

    function automatic logic [N_W-1:0] binom_mod_p(logic [N_W-1:0] n, logic [K_W-1:0] k);
        logic [63:0] falling;
        logic [63:0] fact;
        logic [63:0] base;
        logic [63:0] inv;
        logic [63:0] e;
        falling = 64'd1;
        fact = 64'd1;
        if (N_W'(k) > n || int'(k) > MAX_CHOOSE)
            return '0;
        for (int i = 1; i <= int'(k); i++)
        begin
            falling = mul_mod_p(falling, (64'(n) - 64'(k) + 64'(i)) % PRIME_WIDE);
            fact = mul_mod_p(fact, 64'(i));
        end
        // Fermat inverse of k!
        base = fact;
        inv = 64'd1;
        e = PRIME_WIDE - 64'd2;
        while (e != 0)
        begin
            if (e[0])
                inv = mul_mod_p(inv, base);
            base = mul_mod_p(base, base);
            e = e >> 1;
        end
        return N_W'(mul_mod_p(falling, inv));
    endfunction

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic offer(logic [N_W-1:0] n, logic [K_W-1:0] k, bit known, logic [N_W-1:0] val);
        while (!steady && $urandom_range(0, 99) < 17)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        set_size <= n;
        choose_count <= k;
        do
            @(posedge clk);
        while (!in_ready);
        binom_due.push_back(known ? val : binom_mod_p(n, k));
        @(negedge clk);
    endtask

    initial
    begin
        logic [N_W-1:0] n;
        logic [K_W-1:0] k;
        int sel;
        directed_rows = '{
            '{30'd0,          16'd0,     1'b1, 30'd1},
            '{30'd0,          16'd1,     1'b1, 30'd0},
            '{30'd0,          16'd65535, 1'b1, 30'd0},
            '{30'd5,          16'd6,     1'b1, 30'd0},
            '{30'd1,          16'd1,     1'b1, 30'd1},
            '{30'd10,         16'd0,     1'b1, 30'd1},
            '{30'd5,          16'd2,     1'b1, 30'd10},
            '{30'd12345,      16'd1,     1'b1, 30'd12345},
            '{30'd1000000006, 16'd0,     1'b1, 30'd1},
            '{30'd1000000006, 16'd1,     1'b1, 30'd1000000006},
            '{30'd1000000007, 16'd1,     1'b1, 30'd0},
            '{30'd1073741823, 16'd0,     1'b1, 30'd1},
            '{30'd1073741823, 16'd1,     1'b1, 30'd73741816},
            '{30'd1000000012, 16'd10,    1'b1, 30'd0},
            '{30'd1000000012, 16'd6,     1'b1, 30'd0},
            '{30'd1000000012, 16'd5,     1'b0, 30'd0},
            '{30'd10,         16'd3,     1'b0, 30'd0},
            '{30'd1000000006, 16'd2,     1'b0, 30'd0},
            '{30'd1073741823, 16'd16,    1'b0, 30'd0},
            '{30'd100,        16'd50,    1'b0, 30'd0},
            '{30'd1000000000, 16'd7,     1'b0, 30'd0},
            '{30'd65534,      16'd65535, 1'b1, 30'd0},
            '{30'd65535,      16'd65535, 1'b1, 30'd1},
            '{30'd1000000006, 16'd65535, 1'b0, 30'd0}
        };
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            offer(directed_rows[i].n, directed_rows[i].k, directed_rows[i].known,
                  directed_rows[i].val);

        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            steady = (i >= 30 && i < 55);
            if (i == 60)
                while (binom_due.size() != 0)
                begin
                    in_valid <= 1'b0;
                    @(negedge clk);
                end
            sel = $urandom_range(0, 99);
            if (i == 75)
            begin
                k = K_W'($urandom_range(32768, 65535));
                n = N_W'($urandom_range(int'(k), int'(N_ALL_ONES)));
            end
            else if (sel < 15)
            begin
                k = K_W'($urandom_range(1, 65535));
                n = N_W'($urandom_range(0, int'(k) - 1));
            end
            else if (sel < 25)
            begin
                n = PRIME + N_W'($urandom_range(0, 40));
                k = K_W'($urandom_range(0, 48));
            end
            else if (sel < 32)
            begin
                n = N_W'($urandom_range(int'(PRIME), int'(N_ALL_ONES)));
                k = K_W'($urandom_range(0, 32));
            end
            else if (sel < 40)
            begin
                n = N_W'($urandom_range(0, 64));
                k = $urandom_range(0, 1) ? K_W'(n) : '0;
            end
            else
            begin
                n = N_W'($urandom);
                k = K_W'($urandom_range(0, 64));
            end
            offer(n, k, 1'b0, '0);
        end
        steady = 1'b0;
        in_valid <= 1'b0;

        while (binom_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        bit hold_pending;
        hold_pending = 1'b1;
        forever
        begin
            @(negedge clk);
            if (hold_pending && results_seen >= HOLD_AFTER)
            begin
                hold_pending = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
                out_ready <= steady || ($urandom_range(0, 99) >= 17);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (binom_due.size() == 0)
            begin
                $error("binomial: no transfer outstanding, actual %0d", binomial);
                fail_count++;
            end
            else
            begin
                binom_want = binom_due.pop_front();
                if (binomial !== binom_want)
                begin
                    $error("binomial: expected %0d, actual %0d", binom_want, binomial);
                    fail_count++;
                end
            end
            results_seen++;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

endmodule
